// ===== rtl/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and constants shared by the printable UTF-8 text validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int MAX_PAYLOAD = 4096;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    STATUS_OPEN    = 2'd0,
    STATUS_VALID   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  // Range rule that applies to the first continuation byte only
  typedef enum logic [2:0] {
    RULE_NONE  = 3'd0,
    RULE_GE_A0 = 3'd1,
    RULE_LT_A0 = 3'd2,
    RULE_GE_90 = 3'd3,
    RULE_LT_90 = 3'd4
  } rule_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] safe_length;
    logic             final_flag;
  } out_t;

  typedef struct packed {
    logic             error_seen;
    logic [1:0]       cont_left;
    rule_t            rule;
    logic [LEN_W-1:0] bytes_seen;
    logic [LEN_W-1:0] prefix_length;
  } st_t;

  localparam st_t ST_CLEAR = '{
    error_seen:    1'b0,
    cont_left:     2'd0,
    rule:          RULE_NONE,
    bytes_seen:    '0,
    prefix_length: '0
  };

endpackage

// ===== rtl/utf8v_byte_check.sv =====
// ----------------------------------------------------------------------------
// utf8v_byte_check
// Per-byte decode: next payload state and the result for one byte.
// ----------------------------------------------------------------------------
module utf8v_byte_check (
  input  utf8v_pkg::st_t cur_st,
  input  utf8v_pkg::in_t item,
  output utf8v_pkg::st_t nxt_st,
  output utf8v_pkg::out_t result
);
  import utf8v_pkg::*;

  logic [7:0]       b;
  logic             last;
  logic [LEN_W-1:0] bytes_inc;
  logic             ok;
  st_t              st;

  assign b    = item.data_byte;
  assign last = item.end_of_payload;

  always_comb begin
    st = cur_st;
    ok = 1'b1;

    bytes_inc = cur_st.bytes_seen;
    if (cur_st.bytes_seen < MAX_LEN) begin
      bytes_inc = cur_st.bytes_seen + LEN_W'(1);
    end
    st.bytes_seen = bytes_inc;

    if (!cur_st.error_seen) begin
      if (cur_st.cont_left != 2'd0) begin
        ok = (b[7:6] == 2'b10);
        case (cur_st.rule)
          RULE_GE_A0: if (b < 8'ha0) ok = 1'b0;
          RULE_LT_A0: if (b >= 8'ha0) ok = 1'b0;
          RULE_GE_90: if (b < 8'h90) ok = 1'b0;
          RULE_LT_90: if (b >= 8'h90) ok = 1'b0;
          default:    ;
        endcase
        if (ok) begin
          st.rule      = RULE_NONE;
          st.cont_left = cur_st.cont_left - 2'd1;
          if (cur_st.cont_left == 2'd1) begin
            st.prefix_length = bytes_inc;
          end
        end
      end else if (!b[7]) begin
        // ASCII: tab, LF and CR are the only control bytes allowed
        ok = !((b < 8'h20 && b != 8'h09 && b != 8'h0a && b != 8'h0d) || b == 8'h7f);
        if (ok) begin
          st.prefix_length = bytes_inc;
        end
      end else if (b[7:5] == 3'b110) begin
        ok = (b >= 8'hc2);
        if (ok) begin
          st.cont_left = 2'd1;
        end
      end else if (b[7:4] == 4'he) begin
        st.cont_left = 2'd2;
        st.rule      = (b == 8'he0) ? RULE_GE_A0 :
                       (b == 8'hed) ? RULE_LT_A0 : RULE_NONE;
      end else if (b[7:3] == 5'b11110) begin
        ok = (b <= 8'hf4);
        if (ok) begin
          st.cont_left = 2'd3;
          st.rule      = (b == 8'hf0) ? RULE_GE_90 :
                         (b == 8'hf4) ? RULE_LT_90 : RULE_NONE;
        end
      end else begin
        ok = 1'b0;
      end
      if (!ok) begin
        st.error_seen = 1'b1;
      end
    end

    // payload ends in the middle of a character
    if (last && !st.error_seen && st.cont_left != 2'd0) begin
      st.error_seen = 1'b1;
    end

    result.status      = st.error_seen ? STATUS_INVALID :
                         (last ? STATUS_VALID : STATUS_OPEN);
    result.safe_length = st.prefix_length;
    result.final_flag  = last;

    nxt_st = last ? ST_CLEAR : st;
  end

endmodule

// ===== rtl/utf8_printable_text_validator_top.sv =====
// ----------------------------------------------------------------------------
// utf8_printable_text_validator_top
// Streaming printable UTF-8 check, one byte and one result per request.
// ----------------------------------------------------------------------------
// Each accepted byte lands in the input register; the result register loads
// from it once the output register is free (empty or taken via out_ready).
// Throughput: one byte per cycle, limited only by out_ready; the per-byte
// decode sits between the two registers.
// Reset (rst_n low, synchronous) empties both registers and clears the
// payload state, so the first byte after reset starts a new payload.
module utf8_printable_text_validator_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  utf8v_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output utf8v_pkg::out_t out_data
);
  import utf8v_pkg::*;

  logic in_valid_r, in_valid_nxt;
  in_t  in_data_r,  in_data_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r,  out_data_nxt;
  st_t  st_r,        st_nxt;

  st_t  chk_st;
  out_t chk_res;
  logic out_free;
  logic advance;

  utf8v_byte_check u_check (
    .cur_st (st_r),
    .item   (in_data_r),
    .nxt_st (chk_st),
    .result (chk_res)
  );

  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_data_nxt   = in_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    st_nxt        = st_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = chk_res;
      st_nxt        = chk_st;
      in_valid_nxt  = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
      in_data_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= ST_CLEAR;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
